// File: hdl/dfr_pkg.sv
package dfr_pkg;

  localparam int ROUND_COUNT_DEF = 16;
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W = 4;
  localparam int KEY_W = 48;
  localparam int BLOCK_W = 64;
  localparam int HALF_W = 32;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEC = 2'd2;

  typedef logic [5:0] idx_t;
  typedef logic [3:0] nib_t;

  localparam idx_t E_TAB [48] = '{
    6'd31, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8,
    6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16,
    6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
    6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd0};

  localparam idx_t P_TAB [32] = '{
    6'd15, 6'd6, 6'd19, 6'd20, 6'd28, 6'd11, 6'd27, 6'd16,
    6'd0, 6'd14, 6'd22, 6'd25, 6'd4, 6'd17, 6'd30, 6'd9,
    6'd1, 6'd7, 6'd23, 6'd13, 6'd31, 6'd26, 6'd2, 6'd8,
    6'd18, 6'd12, 6'd29, 6'd5, 6'd21, 6'd10, 6'd3, 6'd24};

  localparam nib_t SBOX [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8, 4'd3, 4'd10, 4'd6, 4'd12,
      4'd5, 4'd9, 4'd0, 4'd7, 4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8, 4'd4, 4'd1, 4'd14, 4'd8,
      4'd13, 4'd6, 4'd2, 4'd11, 4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7, 4'd5, 4'd11, 4'd3, 4'd14,
      4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4, 4'd9, 4'd7, 4'd2, 4'd13,
      4'd12, 4'd0, 4'd5, 4'd10, 4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5, 4'd0, 4'd14, 4'd7, 4'd11,
      4'd10, 4'd4, 4'd13, 4'd1, 4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2, 4'd11, 4'd6, 4'd7, 4'd12,
      4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5, 4'd1, 4'd13, 4'd12, 4'd7,
      4'd11, 4'd4, 4'd2, 4'd8, 4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1, 4'd13, 4'd6, 4'd4, 4'd9,
      4'd8, 4'd15, 4'd3, 4'd0, 4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7, 4'd4, 4'd15, 4'd14, 4'd3,
      4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10, 4'd1, 4'd2, 4'd8, 4'd5,
      4'd11, 4'd12, 4'd4, 4'd15, 4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9, 4'd10, 4'd6, 4'd9, 4'd0,
      4'd12, 4'd11, 4'd7, 4'd13, 4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8, 4'd9, 4'd4, 4'd5, 4'd11,
      4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6, 4'd8, 4'd5, 4'd3, 4'd15,
      4'd13, 4'd0, 4'd14, 4'd9, 4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2, 4'd1, 4'd11,
      4'd10, 4'd13, 4'd7, 4'd8, 4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13, 4'd6, 4'd15, 4'd0, 4'd9,
      4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8, 4'd0, 4'd13, 4'd3, 4'd4,
      4'd14, 4'd7, 4'd5, 4'd11, 4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8, 4'd9, 4'd14, 4'd15, 4'd5,
      4'd2, 4'd8, 4'd12, 4'd3, 4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10, 4'd11, 4'd14, 4'd1, 4'd7,
      4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13, 4'd3, 4'd12, 4'd9, 4'd7,
      4'd5, 4'd10, 4'd6, 4'd1, 4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6, 4'd1, 4'd4, 4'd11, 4'd13,
      4'd12, 4'd3, 4'd7, 4'd14, 4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7, 4'd9, 4'd5, 4'd0, 4'd15,
      4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1, 4'd10, 4'd9, 4'd3, 4'd14,
      4'd5, 4'd0, 4'd12, 4'd7, 4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2, 4'd7, 4'd11, 4'd4, 4'd1,
      4'd9, 4'd12, 4'd14, 4'd2, 4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13, 4'd15, 4'd12, 4'd9, 4'd0,
      4'd3, 4'd5, 4'd6, 4'd11}};

  // round function; bit 0 of the des numbering is the msb
  function automatic logic [HALF_W-1:0] feistel_f(input logic [HALF_W-1:0] r,
                                                  input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] x;
    logic [HALF_W-1:0] s;
    logic [HALF_W-1:0] p;
    logic [5:0] six;
    for (int i = 0; i < 48; i++) begin
      x[47-i] = r[31-E_TAB[i]];
    end
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) begin
      p[31-i] = s[31-P_TAB[i]];
    end
    return p;
  endfunction

endpackage

// File: hdl/dfr_if.sv
interface dfr_in_if;
  logic valid;
  logic ready;
  logic [dfr_pkg::KIND_W-1:0] kind;
  logic [dfr_pkg::SLOT_W-1:0] key_slot;
  logic [dfr_pkg::KEY_W-1:0] round_key;
  logic [dfr_pkg::BLOCK_W-1:0] block_in;
  modport source (output valid, kind, key_slot, round_key, block_in, input ready);
  modport sink (input valid, kind, key_slot, round_key, block_in, output ready);
endinterface

interface dfr_out_if;
  logic valid;
  logic ready;
  logic [dfr_pkg::BLOCK_W-1:0] block_out;
  modport source (output valid, block_out, input ready);
  modport sink (input valid, block_out, output ready);
endinterface

// File: hdl/dfr_round.sv
// one feistel round stage with its own pipeline register
module dfr_round #(
  parameter bit LAST = 1'b0
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic in_dec,
  input  logic [dfr_pkg::HALF_W-1:0] in_l,
  input  logic [dfr_pkg::HALF_W-1:0] in_r,
  input  logic [dfr_pkg::KEY_W-1:0] key,
  output logic out_valid,
  output logic out_dec,
  output logic [dfr_pkg::HALF_W-1:0] out_l,
  output logic [dfr_pkg::HALF_W-1:0] out_r
);
  logic [dfr_pkg::HALF_W-1:0] t;

  assign t = in_l ^ dfr_pkg::feistel_f(in_r, key);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_dec <= in_dec;
      out_l <= LAST ? t : in_r;
      out_r <= LAST ? in_r : t;
    end
  end
endmodule

// File: hdl/des_feistel_rounds.sv
// channel  dir  payload                                 notes
// in       in   kind, key_slot, round_key, block_in     key load or block request
// out      out  block_out                               one per encrypt/decrypt
//
// one round per register stage: ROUND_COUNT stages
// a block request enters every cycle while the pipeline advances (one item per cycle)
// a key load waits until every stage is empty, then writes the key store at acceptance
// key loads leave no result; the unused kind is accepted and dropped
// the pipeline advances when the last stage is empty or its result is taken;
// a stall freezes all stages, nothing is lost or repeated
// rst is synchronous; it empties the pipeline and clears the key store
module des_feistel_rounds #(
  parameter int ROUND_COUNT = dfr_pkg::ROUND_COUNT_DEF
) (
  input logic clk,
  input logic rst,
  dfr_in_if.sink in_ch,
  dfr_out_if.source out_ch
);
  localparam int N = ROUND_COUNT;

  // key store, flops since every stage reads its own slot
  logic [dfr_pkg::KEY_W-1:0] keys [dfr_pkg::SLOT_COUNT];

  logic adv;
  logic acc;
  logic blk;
  logic is_load;
  logic pipe_empty;
  logic [N:0] v;
  logic [N:0] d;
  logic [dfr_pkg::HALF_W-1:0] l [N+1];
  logic [dfr_pkg::HALF_W-1:0] r [N+1];

  // stall only when a finished result waits and is not taken
  assign adv = !v[N] || out_ch.ready;
  // no block may be in flight when a key changes, or its later rounds
  // would see the new key
  assign pipe_empty = !(|v[N:1]);
  assign is_load = in_ch.kind == dfr_pkg::KIND_LOAD;
  assign in_ch.ready = adv && (!is_load || pipe_empty);
  assign acc = in_ch.valid && in_ch.ready;
  assign blk = in_ch.kind == dfr_pkg::KIND_ENC || in_ch.kind == dfr_pkg::KIND_DEC;

  assign v[0] = acc && blk;
  assign d[0] = in_ch.kind == dfr_pkg::KIND_DEC;
  assign l[0] = in_ch.block_in[63:32];
  assign r[0] = in_ch.block_in[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dfr_pkg::SLOT_COUNT; i++) begin
        keys[i] <= '0;
      end
    end else if (acc && is_load) begin
      keys[in_ch.key_slot] <= in_ch.round_key;
    end
  end

  // key loads only happen while the pipe is idle, so stage keys are stable
  for (genvar g = 0; g < N; g++) begin : g_rnd
    localparam logic [dfr_pkg::SLOT_W-1:0] ENC_SLOT = dfr_pkg::SLOT_W'(g);
    localparam logic [dfr_pkg::SLOT_W-1:0] DEC_SLOT = dfr_pkg::SLOT_W'(N - 1 - g);
    logic [dfr_pkg::KEY_W-1:0] k;
    assign k = d[g] ? keys[DEC_SLOT] : keys[ENC_SLOT];
    dfr_round #(.LAST(g == N - 1)) u_rnd (
      .clk(clk), .rst(rst), .adv(adv),
      .in_valid(v[g]), .in_dec(d[g]), .in_l(l[g]), .in_r(r[g]), .key(k),
      .out_valid(v[g+1]), .out_dec(d[g+1]), .out_l(l[g+1]), .out_r(r[g+1])
    );
  end

  assign out_ch.valid = v[N];
  assign out_ch.block_out = {l[N], r[N]};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.block_out))
    else $error("stalled result changed");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid && !is_load |-> in_ch.ready)
    else $error("empty output stalls input");
  a_noload: assert property (@(posedge clk) disable iff (rst)
    acc && is_load |=> !v[1])
    else $error("key load entered pipeline");
  a_loadidle: assert property (@(posedge clk) disable iff (rst)
    acc && is_load |-> pipe_empty)
    else $error("key load while blocks in flight");
endmodule
